// ===== rtl/knnl_pkg.sv =====
// ----------------------------------------------------------------------------
// knnl_pkg
// Shared types and constants for the k-nearest-neighbor list update block.
// ----------------------------------------------------------------------------
package knnl_pkg;

   // Field widths fixed by the transaction format.
   localparam int MODE_W  = 2;
   localparam int PT_W    = 10;
   localparam int POS_W   = 4;
   localparam int COORD_W = 16;
   localparam int ID_W    = 10;
   localparam int DIST_W  = 40;

   // A point index widened so that it compares against any point count.
   localparam int EXT_W   = 17;
   // Difference of two coordinates and its square.
   localparam int DIFF_W  = COORD_W + 1;
   localparam int SQ_W    = 2 * COORD_W + 1;
   // Position compares against slot and dimension counts up to sixteen.
   localparam int CNT_W   = POS_W + 1;

   // Default sizes.
   localparam int POINTS_DEF     = 1024;
   localparam int NEIGHBOURS_DEF = 8;
   localparam int DIMS_DEF       = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD_COORD = 2'd0,
      MODE_LOAD_SLOT  = 2'd1,
      MODE_OFFER      = 2'd2,
      MODE_READ_SLOT  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type                   mode;
      logic [PT_W-1:0]            point;
      logic [POS_W-1:0]           position;
      logic signed [COORD_W-1:0]  coordinate;
      logic [ID_W-1:0]            neighbour_id;
      logic [ID_W-1:0]            candidate;
      logic [DIST_W-1:0]          candidate_dist;
   } req_type;

   typedef struct packed {
      logic              added;
      logic              already_present;
      logic [DIST_W-1:0] furthest_dist;
      logic [ID_W-1:0]   read_neighbour;
   } rsp_type;

   // Control that travels alongside one coordinate pair through the distance unit.
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic q_zero;
   } dist_ctl_type;

endpackage

// ===== rtl/knnl_dist_unit.sv =====
// ----------------------------------------------------------------------------
// knnl_dist_unit
// Coordinate memory with two read ports and a squared-distance accumulator
// that takes one dimension per cycle.
// ----------------------------------------------------------------------------
module knnl_dist_unit #(
   parameter int POINTS = knnl_pkg::POINTS_DEF,
   parameter int DIMS   = knnl_pkg::DIMS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  knnl_pkg::dist_ctl_type                ctl,
   input  logic [$clog2(POINTS*DIMS)-1:0]        p_addr,
   input  logic [$clog2(POINTS*DIMS)-1:0]        q_addr,
   input  logic                                  wr_en,
   input  logic [$clog2(POINTS*DIMS)-1:0]        wr_addr,
   input  logic signed [knnl_pkg::COORD_W-1:0]   wr_data,
   output logic                                  dist_valid,
   output logic [knnl_pkg::DIST_W-1:0]           dist_sum
);
   import knnl_pkg::*;

   logic signed [COORD_W-1:0] coord_mem [POINTS*DIMS];
   logic signed [COORD_W-1:0] p_rd_ff;
   logic signed [COORD_W-1:0] q_rd_ff;

   dist_ctl_type c1_ff;
   dist_ctl_type c2_ff;

   logic signed [DIFF_W-1:0]   diff;
   logic signed [COORD_W-1:0]  q_val;
   logic signed [2*DIFF_W-1:0] prod;
   logic [SQ_W-1:0]            sq_ff;
   logic [SQ_W-1:0]            sq_in;
   logic [DIST_W-1:0]          acc_ff;
   logic [DIST_W-1:0]          acc_in;
   logic                       out_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coord_mem[wr_addr] <= wr_data;
      end
      if (ctl.valid) begin
         p_rd_ff <= coord_mem[p_addr];
         q_rd_ff <= coord_mem[q_addr];
      end
   end

   // A listed id outside the point range has all coordinates at zero.
   always_comb begin
      q_val = c1_ff.q_zero ? '0 : q_rd_ff;
      diff  = DIFF_W'(p_rd_ff) - DIFF_W'(q_val);
      prod  = diff * diff;
      sq_in = prod[SQ_W-1:0];
   end

   assign acc_in = (c2_ff.first ? '0 : acc_ff) + DIST_W'(sq_ff);

   always_ff @(posedge clock) begin
      if (c1_ff.valid) begin
         sq_ff <= sq_in;
      end
      if (c2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff        <= '0;
         c2_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         c1_ff        <= ctl;
         c2_ff        <= c1_ff;
         out_valid_ff <= c2_ff.valid && c2_ff.last;
      end
   end

   assign dist_valid = out_valid_ff;
   assign dist_sum   = acc_ff;

endmodule

// ===== rtl/knn_list_replace_furthest.sv =====
// ----------------------------------------------------------------------------
// knn_list_replace_furthest
// Per-point neighbor lists with furthest-neighbor replacement.
// ----------------------------------------------------------------------------
// One transaction is in work at a time. A load, a slot read or an offer for
// a point out of range passes through a read state that loads its response
// into the output register, and the block then returns to idle. An offer for
// a point in range streams the point's neighbor slots through the coordinate
// memory, one dimension per cycle, through the slot read, coordinate read,
// squaring, accumulation and decision stages, and the block returns to idle
// once the decision is made. A finished response waits in the output
// register without blocking the next transaction's work, but that
// transaction's response keeps the input stalled until the register is free.
// After reset the furthest-distance memory is cleared one entry per cycle,
// so no transaction is accepted until every entry is cleared.
// ----------------------------------------------------------------------------
module knn_list_replace_furthest #(
   parameter int POINTS     = knnl_pkg::POINTS_DEF,
   parameter int NEIGHBOURS = knnl_pkg::NEIGHBOURS_DEF,
   parameter int DIMS       = knnl_pkg::DIMS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  knnl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output knnl_pkg::rsp_type rsp_data
);
   import knnl_pkg::*;

   localparam int PW  = $clog2(POINTS);
   localparam int NAW = $clog2(POINTS * NEIGHBOURS);
   localparam int CAW = $clog2(POINTS * DIMS);
   localparam int SW  = $clog2(NEIGHBOURS);
   localparam int DW  = (DIMS > 1) ? $clog2(DIMS) : 1;

   localparam logic [EXT_W-1:0] PT_LIMIT   = EXT_W'(POINTS);
   localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(NEIGHBOURS);
   localparam logic [CNT_W-1:0] DIM_LIMIT  = CNT_W'(DIMS);
   localparam logic [SW-1:0]    LAST_SLOT  = SW'(NEIGHBOURS - 1);
   localparam logic [DW-1:0]    LAST_DIM   = DW'(DIMS - 1);
   localparam logic [PW-1:0]    LAST_PT    = PW'(POINTS - 1);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_READ   = 6'b000100,
      ST_ISSUE  = 6'b001000,
      ST_DRAIN  = 6'b010000,
      ST_DECIDE = 6'b100000
   } state_type;

   function automatic logic [PW-1:0] pt_index(input logic [PT_W-1:0] p);
      logic [EXT_W-1:0] e;
      e = EXT_W'(p);
      return e[PW-1:0];
   endfunction

   function automatic logic [NAW-1:0] slot_addr(input logic [PW-1:0] p,
                                                input logic [NAW-1:0] s);
      return NAW'(p) * NAW'(NEIGHBOURS) + s;
   endfunction

   function automatic logic [CAW-1:0] coord_addr(input logic [PW-1:0] p,
                                                 input logic [CAW-1:0] d);
      return CAW'(p) * CAW'(DIMS) + d;
   endfunction

   state_type state_ff, state_in;
   logic [PW-1:0] clr_ff, clr_in;

   req_type req_ff;
   logic    pt_ok_ff;

   logic [SW-1:0] a_k_ff, a_k_in;
   logic [DW-1:0] a_d_ff, a_d_in;
   logic          b_valid_ff, b_valid_in;
   logic          b_first_ff, b_last_ff;
   logic [DW-1:0] b_d_ff;

   logic              dup_ff, dup_in;
   logic [SW-1:0]     e_k_ff, e_k_in;
   logic [SW-1:0]     far_k_ff, far_k_in;
   logic [DIST_W-1:0] far_ff, far_in;
   logic [DIST_W-1:0] second_ff, second_in;
   logic              second_ok_ff, second_ok_in;

   logic [ID_W-1:0]   nbr_mem [POINTS*NEIGHBOURS];
   logic [ID_W-1:0]   nbr_rd_ff;
   logic              nbr_we, nbr_re;
   logic [NAW-1:0]    nbr_waddr, nbr_raddr;
   logic [ID_W-1:0]   nbr_wdata;

   logic [DIST_W-1:0] furth_mem [POINTS];
   logic [DIST_W-1:0] furth_rd_ff;
   logic              furth_we, furth_re;
   logic [PW-1:0]     furth_waddr, furth_raddr;
   logic [DIST_W-1:0] furth_wdata;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    rsp_load, rsp_free;

   logic [PW-1:0]     acc_pidx, cur_pidx, q_pidx;
   logic              acc_pt_ok, id_oob, rd_ok, offer_add;
   logic [DIST_W-1:0] new_far;

   dist_ctl_type      dctl;
   logic [CAW-1:0]    p_addr, q_addr;
   logic              coord_we;
   logic              dist_valid;
   logic [DIST_W-1:0] dist_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign acc_pidx  = pt_index(req_data.point);
   assign acc_pt_ok = (EXT_W'(req_data.point) < PT_LIMIT);
   assign cur_pidx  = pt_index(req_ff.point);

   // The slot read for the current neighbor stays in nbr_rd_ff for all of
   // its dimensions, since the next slot read is issued only with dimension 0.
   assign id_oob = (EXT_W'(nbr_rd_ff) >= PT_LIMIT);
   assign q_pidx = pt_index(nbr_rd_ff);

   always_comb begin
      dctl.valid  = b_valid_ff;
      dctl.first  = b_first_ff;
      dctl.last   = b_last_ff;
      dctl.q_zero = id_oob;
      p_addr      = coord_addr(cur_pidx, CAW'(b_d_ff));
      q_addr      = coord_addr(q_pidx, CAW'(b_d_ff));
   end

   assign rd_ok     = (req_ff.mode == MODE_READ_SLOT) &&
                      ({1'b0, req_ff.position} < SLOT_LIMIT);
   assign offer_add = (req_ff.candidate_dist < far_ff);
   assign new_far   = (second_ok_ff && (req_ff.candidate_dist <= second_ff)) ?
                      second_ff : req_ff.candidate_dist;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      a_k_in       = a_k_ff;
      a_d_in       = a_d_ff;
      b_valid_in   = 1'b0;
      dup_in       = dup_ff;
      e_k_in       = e_k_ff;
      far_k_in     = far_k_ff;
      far_in       = far_ff;
      second_in    = second_ff;
      second_ok_in = second_ok_ff;
      nbr_we       = 1'b0;
      nbr_waddr    = '0;
      nbr_wdata    = '0;
      nbr_re       = 1'b0;
      nbr_raddr    = '0;
      furth_we     = 1'b0;
      furth_waddr  = '0;
      furth_wdata  = '0;
      furth_re     = 1'b0;
      furth_raddr  = '0;
      coord_we     = 1'b0;
      rsp_load     = 1'b0;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            furth_we    = 1'b1;
            furth_waddr = clr_ff;
            if (clr_ff == LAST_PT) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + PW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               furth_re    = 1'b1;
               furth_raddr = acc_pidx;
               unique case (req_data.mode)
                  MODE_LOAD_COORD: begin
                     coord_we = acc_pt_ok && ({1'b0, req_data.position} < DIM_LIMIT);
                  end
                  MODE_LOAD_SLOT: begin
                     nbr_we    = acc_pt_ok && ({1'b0, req_data.position} < SLOT_LIMIT);
                     nbr_waddr = slot_addr(acc_pidx, NAW'(req_data.position));
                     nbr_wdata = req_data.neighbour_id;
                  end
                  MODE_READ_SLOT: begin
                     nbr_re    = 1'b1;
                     nbr_raddr = slot_addr(acc_pidx, NAW'(req_data.position));
                  end
                  MODE_OFFER: begin
                  end
               endcase
               a_k_in = '0;
               a_d_in = '0;
               dup_in = 1'b0;
               e_k_in = '0;
               if (req_data.mode == MODE_OFFER && acc_pt_ok) begin
                  state_in = ST_ISSUE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               rsp_in   = '0;
               if (pt_ok_ff) begin
                  rsp_in.furthest_dist  = furth_rd_ff;
                  rsp_in.read_neighbour = rd_ok ? nbr_rd_ff : '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_ISSUE: begin
            b_valid_in = 1'b1;
            nbr_re     = (a_d_ff == '0);
            nbr_raddr  = slot_addr(cur_pidx, NAW'(a_k_ff));
            if (a_d_ff == LAST_DIM) begin
               a_d_in = '0;
               if (a_k_ff == LAST_SLOT) begin
                  state_in = ST_DRAIN;
               end else begin
                  a_k_in = a_k_ff + SW'(1);
               end
            end else begin
               a_d_in = a_d_ff + DW'(1);
            end
         end
         ST_DRAIN: begin
            if (dist_valid && (e_k_ff == LAST_SLOT)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               rsp_in   = '0;
               if (dup_ff) begin
                  rsp_in.already_present = 1'b1;
                  rsp_in.furthest_dist   = furth_rd_ff;
               end else begin
                  furth_we    = 1'b1;
                  furth_waddr = cur_pidx;
                  if (offer_add) begin
                     nbr_we       = 1'b1;
                     nbr_waddr    = slot_addr(cur_pidx, NAW'(far_k_ff));
                     nbr_wdata    = req_ff.candidate;
                     furth_wdata  = new_far;
                     rsp_in.added = 1'b1;
                  end else begin
                     furth_wdata = far_ff;
                  end
                  rsp_in.furthest_dist = furth_wdata;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Duplicate search: one slot id is compared when its first dimension passes.
      if (b_valid_ff && b_first_ff && (nbr_rd_ff == req_ff.candidate)) begin
         dup_in = 1'b1;
      end

      // Furthest and second-furthest tracking; ties keep the earlier slot.
      if (dist_valid) begin
         e_k_in = e_k_ff + SW'(1);
         priority if (e_k_ff == '0) begin
            far_in       = dist_sum;
            far_k_in     = '0;
            second_ok_in = 1'b0;
         end else if (dist_sum > far_ff) begin
            second_in    = far_ff;
            second_ok_in = 1'b1;
            far_in       = dist_sum;
            far_k_in     = e_k_ff;
         end else if (!second_ok_ff || (dist_sum > second_ff)) begin
            second_in    = dist_sum;
            second_ok_in = 1'b1;
         end else begin
            // Neither the furthest nor the second-furthest changes.
            second_in = second_ff;
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   knnl_dist_unit #(
      .POINTS (POINTS),
      .DIMS   (DIMS)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .ctl        (dctl),
      .p_addr     (p_addr),
      .q_addr     (q_addr),
      .wr_en      (coord_we),
      .wr_addr    (coord_addr(acc_pidx, CAW'(req_data.position))),
      .wr_data    (req_data.coordinate),
      .dist_valid (dist_valid),
      .dist_sum   (dist_sum)
   );

   always_ff @(posedge clock) begin
      if (nbr_we) begin
         nbr_mem[nbr_waddr] <= nbr_wdata;
      end
      if (nbr_re) begin
         nbr_rd_ff <= nbr_mem[nbr_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (furth_we) begin
         furth_mem[furth_waddr] <= furth_wdata;
      end
      if (furth_re) begin
         furth_rd_ff <= furth_mem[furth_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         req_ff   <= req_data;
         pt_ok_ff <= acc_pt_ok;
      end
      if (state_ff == ST_ISSUE) begin
         b_first_ff <= (a_d_ff == '0);
         b_last_ff  <= (a_d_ff == LAST_DIM);
         b_d_ff     <= a_d_ff;
      end
      far_ff    <= far_in;
      second_ff <= second_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         a_k_ff       <= '0;
         a_d_ff       <= '0;
         b_valid_ff   <= 1'b0;
         dup_ff       <= 1'b0;
         e_k_ff       <= '0;
         far_k_ff     <= '0;
         second_ok_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         a_k_ff       <= a_k_in;
         a_d_ff       <= a_d_in;
         b_valid_ff   <= b_valid_in;
         dup_ff       <= dup_in;
         e_k_ff       <= e_k_in;
         far_k_ff     <= far_k_in;
         second_ok_ff <= second_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!b_valid_ff && !dist_valid))
      else $error("transaction accepted while the distance pipeline is busy");

   a_stall_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transaction accepted before the first completed");

   a_dist_in_offer: assert property (@(posedge clock) disable iff (reset)
      dist_valid |-> (state_ff == ST_ISSUE || state_ff == ST_DRAIN))
      else $error("distance result outside an offer");

   a_clear_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (!rsp_load && !furth_re))
      else $error("response or read during the clearing pass");

   a_added_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.added) |-> !rsp_data.already_present)
      else $error("response both added and already present");

endmodule
